// ===== src/ffti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffti_pkg;

    // Widths of the vector and time fields, fixed by the request format.
    localparam int DATA_W = 32;
    localparam int TIME_W = 31;
    localparam int REQ_W  = 3;
    localparam int ID_W   = 3;
    localparam int STAT_W = 2;

    // Request codes carried in req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND   = 3'd0,
        REQ_SET      = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_IMPULSE  = 3'd3,
        REQ_INTEGRAL = 3'd4,
        REQ_CLEAR    = 3'd5
    } ffti_req_t;

    // Status codes returned with each result.
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2
    } ffti_status_t;

    // One 3-D vector in signed Q16.16.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } ffti_vec_t;

    // Step controls for the shared scaling multiplier.
    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
    } ffti_scale_ctl_t;

endpackage

`default_nettype wire

// ===== src/ffti_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ffti_req_if;

    logic                                   valid;
    logic                                   ready;
    logic [ffti_pkg::REQ_W-1:0]             req_type;
    logic [ffti_pkg::ID_W-1:0]              factor_id;
    logic signed [ffti_pkg::DATA_W-1:0]     vec_x;
    logic signed [ffti_pkg::DATA_W-1:0]     vec_y;
    logic signed [ffti_pkg::DATA_W-1:0]     vec_z;
    logic [ffti_pkg::TIME_W-1:0]            time_step;

    modport source (
        output valid, req_type, factor_id, vec_x, vec_y, vec_z, time_step,
        input  ready
    );

    modport sink (
        input  valid, req_type, factor_id, vec_x, vec_y, vec_z, time_step,
        output ready
    );

endinterface

`default_nettype wire

// ===== src/ffti_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ffti_rsp_if;

    logic                                   valid;
    logic                                   ready;
    logic [ffti_pkg::STAT_W-1:0]            status;
    logic [ffti_pkg::ID_W-1:0]              assigned_id;
    logic signed [ffti_pkg::DATA_W-1:0]     sum_x;
    logic signed [ffti_pkg::DATA_W-1:0]     sum_y;
    logic signed [ffti_pkg::DATA_W-1:0]     sum_z;

    modport source (
        output valid, status, assigned_id, sum_x, sum_y, sum_z,
        input  ready
    );

    modport sink (
        input  valid, status, assigned_id, sum_x, sum_y, sum_z,
        output ready
    );

endinterface

`default_nettype wire

// ===== src/ffti_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffti_slot_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ffti_pkg::ffti_vec_t wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ffti_pkg::ffti_vec_t rd_data
);
    import ffti_pkg::*;

    ffti_vec_t mem [DEPTH];
    ffti_vec_t rd_data_reg;

    // Single write port; read data is only summed while its slot's used bit is set.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/ffti_scale_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffti_scale_unit #(
    parameter int ACC_W = 36
) (
    input  logic                            clk,
    input  logic signed [ACC_W-1:0]         acc_val,
    input  logic [ffti_pkg::TIME_W-1:0]     time_step,
    input  ffti_pkg::ffti_scale_ctl_t       ctl,
    output logic signed [ffti_pkg::DATA_W-1:0] result
);
    import ffti_pkg::*;

    localparam int HALF_W = 16;
    localparam int PROD_W = ACC_W + HALF_W;
    localparam int Q_W    = PROD_W + 1;

    logic              neg;
    logic [ACC_W-1:0]  acc_u;
    logic [ACC_W-1:0]  mag;
    logic [HALF_W-1:0] op;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  lo_reg;
    logic [Q_W-1:0]    q;

    // Sign and magnitude of the axis sum.
    assign acc_u = acc_val;
    assign neg   = acc_val[ACC_W-1];
    assign mag   = neg ? (~acc_u + ACC_W'(1)) : acc_u;

    // The shared multiplier takes the low time half first, then the high half.
    assign op   = ctl.mul_hi ? {1'b0, time_step[TIME_W-1:HALF_W]}
                             : time_step[HALF_W-1:0];
    assign prod = PROD_W'(mag) * PROD_W'(op);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_lo)
        begin
            prod_reg <= prod;
        end
        else if (ctl.mul_hi)
        begin
            lo_reg   <= prod_reg[PROD_W-1:HALF_W];
            prod_reg <= prod;
        end
    end

    // Combine the halves, restore the sign and saturate to 32 bits.
    assign q = {1'b0, prod_reg} + Q_W'(lo_reg);

    always_comb
    begin
        if (neg)
        begin
            if (q >= Q_W'(32'h8000_0000))
            begin
                result = 32'sh8000_0000;
            end
            else
            begin
                result = 32'd0 - q[DATA_W-1:0];
            end
        end
        else
        begin
            if (q > Q_W'(32'h7FFF_FFFF))
            begin
                result = 32'sh7FFF_FFFF;
            end
            else
            begin
                result = q[DATA_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/force_factor_table_integrator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Factor-table integrator.
// Requests arrive on the req channel and each gives exactly one result
// transaction on the rsp channel, in order. Both use valid/ready; a
// transaction completes at a rising edge where both are high.
// The block works on one request at a time and raises req.ready only when
// idle. Each accepted request is decoded and then handled as follows:
//   set, remove, impulse, clear, unknown code: straight to the result stage
//   append: search for the lowest free slot (one used bit is examined per cycle)
//   integral: one table slot is read per cycle from the slot memory, then
//     one shared multiplier scales the three axes in turn, each with a
//     low-half multiply, a high-half multiply and a saturate step
// A new request can be accepted in the cycle after the result is loaded.
// The result sits in an output register; while the receiver stalls, the
// next request is still accepted and runs up to its own result stage.
// Reset clears the used bits, the base vector and all handshake state; the
// slot memory is not cleared, as its entries are only summed while in use.
module force_factor_table_integrator_core #(
    parameter int MAX_FACTORS = 8
) (
    input  logic   clk,
    input  logic   rst_n,
    ffti_req_if.sink   req,
    ffti_rsp_if.source rsp
);
    import ffti_pkg::*;

    localparam int IDX_W = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int ACC_W = DATA_W + $clog2(MAX_FACTORS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FACTORS - 1);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_SUM,
        S_DRAIN,
        S_MUL_LO,
        S_MUL_HI,
        S_SAT,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [REQ_W-1:0]          req_type_reg, req_type_next;
    logic [ID_W-1:0]           id_reg, id_next;
    ffti_vec_t                 vec_reg, vec_next;
    logic [TIME_W-1:0]         time_reg, time_next;
    logic [MAX_FACTORS-1:0]    slot_used_reg, slot_used_next;
    ffti_vec_t                 base_reg, base_next;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      rd_used_reg, rd_used_next;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0]   acc_y_reg, acc_y_next;
    logic signed [ACC_W-1:0]   acc_z_reg, acc_z_next;
    logic [1:0]                axis_reg, axis_next;
    ffti_status_t              res_status_reg, res_status_next;
    logic [ID_W-1:0]           res_aid_reg, res_aid_next;
    ffti_vec_t                 res_sum_reg, res_sum_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    ffti_status_t              out_status_reg, out_status_next;
    logic [ID_W-1:0]           out_aid_reg, out_aid_next;
    ffti_vec_t                 out_sum_reg, out_sum_next;

    logic [IDX_W+ID_W-1:0]     id_wide;
    logic [IDX_W-1:0]          id_idx;
    logic                      id_known;
    logic [IDX_W+ID_W-1:0]     cnt_wide;
    logic                      mem_wr_en;
    logic [IDX_W-1:0]          mem_wr_addr;
    ffti_vec_t                 mem_rd_data;
    logic signed [ACC_W-1:0]   scale_in;
    logic signed [DATA_W-1:0]  scale_out;
    ffti_scale_ctl_t           scale_ctl;

    // Saturating 32-bit add for impulses.
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
        begin
            return s[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sext(input logic signed [DATA_W-1:0] v);
        return {{(ACC_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // Id lookup; ids at or above the table size are never in use.
    assign id_wide  = {IDX_W'(0), id_reg};
    assign id_idx   = id_wide[IDX_W-1:0];
    assign id_known = (32'(id_reg) < 32'(MAX_FACTORS)) && slot_used_reg[id_idx];
    assign cnt_wide = {ID_W'(0), cnt_reg};

    ffti_slot_mem #(
        .DEPTH  (MAX_FACTORS),
        .ADDR_W (IDX_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (vec_reg),
        .rd_addr (cnt_reg),
        .rd_data (mem_rd_data)
    );

    // Axis sum presented to the shared scaling unit.
    always_comb
    begin
        case (axis_reg)
            AXIS_X:  scale_in = acc_x_reg;
            AXIS_Y:  scale_in = acc_y_reg;
            default: scale_in = acc_z_reg;
        endcase
    end

    assign scale_ctl.mul_lo = (state_reg == S_MUL_LO);
    assign scale_ctl.mul_hi = (state_reg == S_MUL_HI);

    ffti_scale_unit #(
        .ACC_W (ACC_W)
    ) u_scale_unit (
        .clk       (clk),
        .acc_val   (scale_in),
        .time_step (time_reg),
        .ctl       (scale_ctl),
        .result    (scale_out)
    );

    // Sequencer next-state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        req_type_next   = req_type_reg;
        id_next         = id_reg;
        vec_next        = vec_reg;
        time_next       = time_reg;
        slot_used_next  = slot_used_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = (state_reg == S_SUM);
        rd_used_next    = slot_used_reg[cnt_reg];
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        acc_z_next      = acc_z_reg;
        axis_next       = axis_reg;
        res_status_next = res_status_reg;
        res_aid_next    = res_aid_reg;
        res_sum_next    = res_sum_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_aid_next    = out_aid_reg;
        out_sum_next    = out_sum_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = cnt_reg;

        // Add the slot read in the previous cycle if it is in use.
        if (rd_vld_reg && rd_used_reg)
        begin
            acc_x_next = acc_x_reg + sext(mem_rd_data.x);
            acc_y_next = acc_y_reg + sext(mem_rd_data.y);
            acc_z_next = acc_z_reg + sext(mem_rd_data.z);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.req_type;
                    id_next       = req.factor_id;
                    vec_next.x    = req.vec_x;
                    vec_next.y    = req.vec_y;
                    vec_next.z    = req.vec_z;
                    time_next     = req.time_step;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_aid_next    = '0;
                res_sum_next    = '0;
                state_next      = S_DONE;
                case (req_type_reg)
                    REQ_APPEND:
                    begin
                        cnt_next   = '0;
                        state_next = S_FIND;
                    end
                    REQ_SET:
                    begin
                        if (id_known)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = id_idx;
                        end
                        else
                        begin
                            res_status_next = ST_UNKNOWN;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (id_known)
                        begin
                            slot_used_next[id_idx] = 1'b0;
                        end
                        else
                        begin
                            res_status_next = ST_UNKNOWN;
                        end
                    end
                    REQ_IMPULSE:
                    begin
                        base_next.x = sat_add(base_reg.x, vec_reg.x);
                        base_next.y = sat_add(base_reg.y, vec_reg.y);
                        base_next.z = sat_add(base_reg.z, vec_reg.z);
                    end
                    REQ_INTEGRAL:
                    begin
                        acc_x_next = sext(base_reg.x);
                        acc_y_next = sext(base_reg.y);
                        acc_z_next = sext(base_reg.z);
                        cnt_next   = '0;
                        state_next = S_SUM;
                    end
                    REQ_CLEAR:
                    begin
                        slot_used_next = '0;
                        base_next      = '0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Search for the lowest free id, one slot per cycle.
            S_FIND:
            begin
                if (!slot_used_reg[cnt_reg])
                begin
                    mem_wr_en               = 1'b1;
                    slot_used_next[cnt_reg] = 1'b1;
                    res_aid_next            = cnt_wide[ID_W-1:0];
                    state_next              = S_DONE;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            // Read every slot in turn; each slot is accumulated in the cycle after its read.
            S_SUM:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end

            S_DRAIN:
            begin
                axis_next  = AXIS_X;
                state_next = S_MUL_LO;
            end

            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end

            S_MUL_HI:
            begin
                state_next = S_SAT;
            end

            // Store the scaled axis and move to the next one.
            S_SAT:
            begin
                case (axis_reg)
                    AXIS_X:  res_sum_next.x = scale_out;
                    AXIS_Y:  res_sum_next.y = scale_out;
                    default: res_sum_next.z = scale_out;
                endcase
                if (axis_reg == AXIS_Z)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL_LO;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_aid_next    = res_aid_reg;
                    out_sum_next    = res_sum_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, table control, datapath and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_type_reg   <= '0;
            id_reg         <= '0;
            vec_reg        <= '0;
            time_reg       <= '0;
            slot_used_reg  <= '0;
            base_reg       <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_used_reg    <= 1'b0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_z_reg      <= '0;
            axis_reg       <= AXIS_X;
            res_status_reg <= ST_OK;
            res_aid_reg    <= '0;
            res_sum_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_aid_reg    <= '0;
            out_sum_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            req_type_reg   <= req_type_next;
            id_reg         <= id_next;
            vec_reg        <= vec_next;
            time_reg       <= time_next;
            slot_used_reg  <= slot_used_next;
            base_reg       <= base_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            rd_used_reg    <= rd_used_next;
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            acc_z_reg      <= acc_z_next;
            axis_reg       <= axis_next;
            res_status_reg <= res_status_next;
            res_aid_reg    <= res_aid_next;
            res_sum_reg    <= res_sum_next;
            rsp_valid_reg  <= rsp_valid_next;
            out_status_reg <= out_status_next;
            out_aid_reg    <= out_aid_next;
            out_sum_reg    <= out_sum_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.assigned_id = out_aid_reg;
    assign rsp.sum_x       = out_sum_reg.x;
    assign rsp.sum_y       = out_sum_reg.y;
    assign rsp.sum_z       = out_sum_reg.z;

    // A full status is only reported when every slot is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_status_reg == ST_FULL) |-> (&slot_used_reg))
        else $error("full status with a free slot");

    // A clear request leaves an empty table and a zero base.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && req_type_reg == REQ_CLEAR)
        |=> (slot_used_reg == '0 && base_reg == '0))
        else $error("clear did not empty the table");

    // A nonzero assigned id only comes with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && out_aid_reg != '0) |-> (out_status_reg == ST_OK))
        else $error("assigned id with error status");

endmodule

`default_nettype wire
